[hw/rtl/cbag_pkg.sv]
package cbag_pkg;

  localparam int SQ_W    = 6;
  localparam int BB_W    = 64;
  localparam int OP_W    = 3;
  localparam int IN_DW   = 72;   // square + occupancy, padded to bytes
  localparam int RAY_LEN = 7;

  typedef enum logic [OP_W-1:0] {
    OP_KING   = 3'd0,
    OP_KNIGHT = 3'd1,
    OP_WPAWN  = 3'd2,
    OP_BPAWN  = 3'd3,
    OP_ROOK   = 3'd4,
    OP_BISHOP = 3'd5
  } op_t;

  // rank / file step, two's complement
  typedef struct packed {
    logic signed [2:0] dr;
    logic signed [2:0] df;
  } ofs_t;

  localparam ofs_t KING_OFS [8] = '{
    '{3'sd1, 3'sd0}, '{3'sd1, 3'sd1}, '{3'sd0, 3'sd1}, '{-3'sd1, 3'sd1},
    '{-3'sd1, 3'sd0}, '{-3'sd1, -3'sd1}, '{3'sd0, -3'sd1}, '{3'sd1, -3'sd1}
  };

  localparam ofs_t KNIGHT_OFS [8] = '{
    '{3'sd2, 3'sd1}, '{3'sd1, 3'sd2}, '{-3'sd1, 3'sd2}, '{-3'sd2, 3'sd1},
    '{-3'sd2, -3'sd1}, '{-3'sd1, -3'sd2}, '{3'sd1, -3'sd2}, '{3'sd2, -3'sd1}
  };

  localparam ofs_t WPAWN_OFS [2] = '{'{3'sd1, -3'sd1}, '{3'sd1, 3'sd1}};
  localparam ofs_t BPAWN_OFS [2] = '{'{-3'sd1, -3'sd1}, '{-3'sd1, 3'sd1}};

  localparam ofs_t ROOK_OFS [4] = '{
    '{3'sd1, 3'sd0}, '{-3'sd1, 3'sd0}, '{3'sd0, 3'sd1}, '{3'sd0, -3'sd1}
  };

  localparam ofs_t BISHOP_OFS [4] = '{
    '{3'sd1, 3'sd1}, '{3'sd1, -3'sd1}, '{-3'sd1, 3'sd1}, '{-3'sd1, -3'sd1}
  };

  // widen a 3-bit step to the 5-bit coordinate space
  function automatic logic signed [4:0] step_ext(input logic signed [2:0] s);
    return $signed({{2{s[2]}}, s});
  endfunction

  // coordinate in 0..7 for a 5-bit signed value
  function automatic logic on_edge_ok(input logic signed [4:0] v);
    return (v[4:3] == 2'b00);
  endfunction

endpackage

[hw/rtl/cbag_leaper.sv]
module cbag_leaper (
  input  logic [cbag_pkg::OP_W-1:0] op,
  input  logic [cbag_pkg::SQ_W-1:0] square,
  output logic [cbag_pkg::BB_W-1:0] attacks
);
  import cbag_pkg::*;

  logic [BB_W-1:0] king_set;
  logic [BB_W-1:0] knight_set;
  logic [BB_W-1:0] wpawn_set;
  logic [BB_W-1:0] bpawn_set;
  logic signed [4:0] r0;
  logic signed [4:0] f0;

  assign r0 = $signed({2'b00, square[5:3]});
  assign f0 = $signed({2'b00, square[2:0]});

  always_comb begin
    logic signed [4:0] r;
    logic signed [4:0] f;
    king_set   = '0;
    knight_set = '0;
    wpawn_set  = '0;
    bpawn_set  = '0;
    for (int i = 0; i < 8; i++) begin
      r = r0 + step_ext(KING_OFS[i].dr);
      f = f0 + step_ext(KING_OFS[i].df);
      if (on_edge_ok(r) && on_edge_ok(f)) king_set[{r[2:0], f[2:0]}] = 1'b1;
      r = r0 + step_ext(KNIGHT_OFS[i].dr);
      f = f0 + step_ext(KNIGHT_OFS[i].df);
      if (on_edge_ok(r) && on_edge_ok(f)) knight_set[{r[2:0], f[2:0]}] = 1'b1;
    end
    for (int i = 0; i < 2; i++) begin
      r = r0 + step_ext(WPAWN_OFS[i].dr);
      f = f0 + step_ext(WPAWN_OFS[i].df);
      if (on_edge_ok(r) && on_edge_ok(f)) wpawn_set[{r[2:0], f[2:0]}] = 1'b1;
      r = r0 + step_ext(BPAWN_OFS[i].dr);
      f = f0 + step_ext(BPAWN_OFS[i].df);
      if (on_edge_ok(r) && on_edge_ok(f)) bpawn_set[{r[2:0], f[2:0]}] = 1'b1;
    end
  end

  always_comb begin
    unique case (op)
      OP_KING:   attacks = king_set;
      OP_KNIGHT: attacks = knight_set;
      OP_WPAWN:  attacks = wpawn_set;
      OP_BPAWN:  attacks = bpawn_set;
      default:   attacks = '0;
    endcase
  end

endmodule

[hw/rtl/cbag_slider.sv]
module cbag_slider (
  input  logic                      is_bishop,
  input  logic [cbag_pkg::SQ_W-1:0] square,
  input  logic [cbag_pkg::BB_W-1:0] occupancy,
  output logic [cbag_pkg::BB_W-1:0] attacks
);
  import cbag_pkg::*;

  logic signed [4:0] r0;
  logic signed [4:0] f0;

  assign r0 = $signed({2'b00, square[5:3]});
  assign f0 = $signed({2'b00, square[2:0]});

  // four rays, seven steps each; a ray keeps the first blocker and stops
  always_comb begin
    logic signed [4:0] r;
    logic signed [4:0] f;
    logic              open;
    ofs_t              dir;
    attacks = '0;
    for (int d = 0; d < 4; d++) begin
      dir  = is_bishop ? BISHOP_OFS[d] : ROOK_OFS[d];
      r    = r0;
      f    = f0;
      open = 1'b1;
      for (int k = 0; k < RAY_LEN; k++) begin
        r = r + step_ext(dir.dr);
        f = f + step_ext(dir.df);
        if (open && on_edge_ok(r) && on_edge_ok(f)) begin
          attacks[{r[2:0], f[2:0]}] = 1'b1;
          if (occupancy[{r[2:0], f[2:0]}]) open = 1'b0;
        end else begin
          open = 1'b0;
        end
      end
    end
  end

endmodule

[hw/rtl/chess_bitboard_attack_generator_core.sv]
// Channel | Dir | Ports                      | Contents
// in_     | in  | tvalid tready tdata tuser  | tuser: op; tdata: square, occupancy
// out_    | out | tvalid tready tdata        | tdata: attacks
//
// Two register stages: an input register, then leaper/slider logic feeding
// the result register. One request per cycle sustained while out_tready stays high.
// The longest path is one slider ray: seven chained square/occupancy steps.
// rst_n is synchronous, active low, and clears only the valid flags.
// A stalled result holds in the result register; the input register still
// takes one more request, then in_tready drops until out_tready frees a slot.
module chess_bitboard_attack_generator_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [cbag_pkg::IN_DW-1:0]  in_tdata,   // [5:0] square, [69:6] occupancy, pad
  input  logic [cbag_pkg::OP_W-1:0]   in_tuser,   // [2:0] op
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [cbag_pkg::BB_W-1:0]   out_tdata   // [63:0] attacks
);
  import cbag_pkg::*;

  // input register
  logic              s1_valid_r;
  logic [OP_W-1:0]   s1_op_r;
  logic [SQ_W-1:0]   s1_square_r;
  logic [BB_W-1:0]   s1_occ_r;

  // result register
  logic              out_valid_r;
  logic [BB_W-1:0]   out_data_r;

  logic              s1_ready;
  logic              s2_ready;
  logic [BB_W-1:0]   leap_set;
  logic [BB_W-1:0]   slide_set;
  logic [BB_W-1:0]   attacks_nxt;

  assign s2_ready  = !out_valid_r || out_tready;
  assign s1_ready  = !s1_valid_r || s2_ready;
  assign in_tready = s1_ready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  cbag_leaper u_leaper (
    .op      (s1_op_r),
    .square  (s1_square_r),
    .attacks (leap_set)
  );

  cbag_slider u_slider (
    .is_bishop (s1_op_r == OP_BISHOP),
    .square    (s1_square_r),
    .occupancy (s1_occ_r),
    .attacks   (slide_set)
  );

  // kinds 6 and 7 name no piece: empty set
  always_comb begin
    unique case (s1_op_r)
      OP_KING, OP_KNIGHT, OP_WPAWN, OP_BPAWN: attacks_nxt = leap_set;
      OP_ROOK, OP_BISHOP:                     attacks_nxt = slide_set;
      default:                                attacks_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_r <= in_tvalid;
      if (s2_ready) out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && s1_ready) begin
      s1_op_r     <= in_tuser;
      s1_square_r <= in_tdata[SQ_W-1:0];
      s1_occ_r    <= in_tdata[SQ_W+BB_W-1:SQ_W];
    end
    if (s1_valid_r && s2_ready) out_data_r <= attacks_nxt;
  end

  // a full input stage moves into a free result slot
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s2_ready) |=> out_valid_r)
    else $error("input stage did not advance into free result register");

  // both stages full and output stalled: no new request may enter
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_tready) |-> !in_tready)
    else $error("request accepted while pipeline full");

  // an empty input stage always takes a request
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_tready)
    else $error("empty input stage not ready");

  // reset empties the pipeline
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> (!s1_valid_r && !out_valid_r))
    else $error("valid flags not cleared by reset");

endmodule

[sim/chess_bitboard_attack_generator_core_tb.sv]
`timescale 1ns / 100ps

module chess_bitboard_attack_generator_core_tb;
  import cbag_pkg::*;

  // Op codes 6 and 7 name no piece; the block must answer with an empty set.
  localparam logic [OP_W-1:0] KIND_UNUSED_LO = 3'd6;
  localparam logic [OP_W-1:0] KIND_UNUSED_HI = 3'd7;

  localparam int PAD_W            = IN_DW - BB_W - SQ_W;
  localparam int RANDOM_PER_PHASE = 476;   // three phases plus the probes, ~1450 requests
  localparam int LONG_HOLD        = 64;    // receiver hold-off, long enough to back up the input
  localparam int DRAIN_TAIL       = 16;    // well past the input and result register stages
  localparam int IDLE_LIMIT       = 2000;  // cycles with no transfer on either side
  localparam int REPORT_MAX       = 10;

  localparam logic [BB_W-1:0] ALL_OCC = {BB_W{1'b1}};

  // One directed probe. Where "typed" is set the expected set is written out
  // by hand; otherwise the predictor supplies it.
  typedef struct packed {
    logic [OP_W-1:0] kind;
    logic [SQ_W-1:0] sq;
    logic [BB_W-1:0] occ;
    logic            typed;
    logic [BB_W-1:0] want;
  } probe_t;

  localparam int NUM_PROBES = 24;
  localparam probe_t PROBES [NUM_PROBES] = '{
    // king: corner, far corner with full board, center
    '{OP_KING,   6'd0,  64'd0,                 1'b1, 64'h0000_0000_0000_0302},
    '{OP_KING,   6'd63, ALL_OCC,               1'b0, 64'd0},
    '{OP_KING,   6'd36, 64'h0123_4567_89ab_cdef, 1'b0, 64'd0},
    // knight: corner, far corner, center
    '{OP_KNIGHT, 6'd0,  64'd0,                 1'b1, 64'h0000_0000_0002_0400},
    '{OP_KNIGHT, 6'd63, ALL_OCC,               1'b0, 64'd0},
    '{OP_KNIGHT, 6'd27, 64'd0,                 1'b0, 64'd0},
    // white pawn: a-file, top rank (nothing), h-file
    '{OP_WPAWN,  6'd8,  64'd0,                 1'b0, 64'd0},
    '{OP_WPAWN,  6'd63, 64'd0,                 1'b1, 64'd0},
    '{OP_WPAWN,  6'd7,  ALL_OCC,               1'b0, 64'd0},
    // black pawn: bottom rank (nothing), center, a-file top
    '{OP_BPAWN,  6'd0,  64'd0,                 1'b1, 64'd0},
    '{OP_BPAWN,  6'd36, ALL_OCC,               1'b0, 64'd0},
    '{OP_BPAWN,  6'd56, 64'd0,                 1'b0, 64'd0},
    // rook: empty board, full board, only the origin occupied, center with blockers, far corner
    '{OP_ROOK,   6'd0,  64'd0,                 1'b1, 64'h0101_0101_0101_01fe},
    '{OP_ROOK,   6'd0,  ALL_OCC,               1'b1, 64'h0000_0000_0000_0102},
    '{OP_ROOK,   6'd0,  64'd1,                 1'b1, 64'h0101_0101_0101_01fe},
    '{OP_ROOK,   6'd27, 64'h0800_2200_0800_0000, 1'b0, 64'd0},
    '{OP_ROOK,   6'd63, 64'd0,                 1'b0, 64'd0},
    // bishop: empty board, full board, origin occupied, checker pattern, h1 corner
    '{OP_BISHOP, 6'd0,  64'd0,                 1'b1, 64'h8040_2010_0804_0200},
    '{OP_BISHOP, 6'd0,  ALL_OCC,               1'b1, 64'h0000_0000_0000_0200},
    '{OP_BISHOP, 6'd63, 64'h8000_0000_0000_0000, 1'b0, 64'd0},
    '{OP_BISHOP, 6'd35, 64'haaaa_5555_aaaa_5555, 1'b0, 64'd0},
    '{OP_BISHOP, 6'd7,  64'd0,                 1'b0, 64'd0},
    // unused kinds: empty set even on a full board
    '{KIND_UNUSED_LO, 6'd27, ALL_OCC,          1'b1, 64'd0},
    '{KIND_UNUSED_HI, 6'd63, ALL_OCC,          1'b1, 64'd0}
  };

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_DW-1:0] in_tdata = '0;
  logic [OP_W-1:0]  in_tuser = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [BB_W-1:0]  out_tdata;

  logic [BB_W-1:0] attacks_due [$];   // expected attack sets, oldest first
  int  fault_count   = 0;
  int  results_seen  = 0;
  int  quiet_cycles  = 0;
  int  send_gap_pct  = 0;
  int  recv_gap_pct  = 0;
  bit  long_hold_req = 1'b0;

  chess_bitboard_attack_generator_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Single-square mask; empty when the coordinate falls off the board.
  function automatic logic [BB_W-1:0] square_mask(input int r, input int f);
    if (r < 0 || r > 7 || f < 0 || f > 7) return '0;
    return 64'd1 << (r * 8 + f);
  endfunction

  // Attack set of one piece. King, knight and slider steps are walked over the 3x3
  // (or 5x5 for the knight) neighborhood rather than from fixed offset lists.
  function automatic logic [BB_W-1:0] attack_set(input logic [OP_W-1:0] kind,
                                                 input logic [SQ_W-1:0] sq,
                                                 input logic [BB_W-1:0] occ);
    int r0, f0, r, f, dr, df, k;
    bit open, is_dir;
    logic [BB_W-1:0] acc, m;
    r0  = int'(sq[5:3]);
    f0  = int'(sq[2:0]);
    acc = '0;
    case (kind)
      OP_KING: begin
        for (dr = -1; dr <= 1; dr++)
          for (df = -1; df <= 1; df++)
            if (dr != 0 || df != 0) acc |= square_mask(r0 + dr, f0 + df);
      end
      OP_KNIGHT: begin
        // the eight (1,2)/(2,1) jumps are exactly the steps with dr^2+df^2 == 5
        for (dr = -2; dr <= 2; dr++)
          for (df = -2; df <= 2; df++)
            if (dr * dr + df * df == 5) acc |= square_mask(r0 + dr, f0 + df);
      end
      OP_WPAWN: acc = square_mask(r0 + 1, f0 - 1) | square_mask(r0 + 1, f0 + 1);
      OP_BPAWN: acc = square_mask(r0 - 1, f0 - 1) | square_mask(r0 - 1, f0 + 1);
      OP_ROOK, OP_BISHOP: begin
        for (dr = -1; dr <= 1; dr++)
          for (df = -1; df <= 1; df++) begin
            is_dir = (kind == OP_ROOK) ? ((dr == 0) != (df == 0)) : (dr != 0 && df != 0);
            if (is_dir) begin
              r = r0;
              f = f0;
              open = 1'b1;
              // ray ends at the edge or on the first blocker, blocker included;
              // the origin's own bit is never looked at
              for (k = 0; k < 7; k++)
                if (open) begin
                  r += dr;
                  f += df;
                  m = square_mask(r, f);
                  acc |= m;
                  if (m == '0 || (occ & m) != '0) open = 1'b0;
                end
            end
          end
      end
      default: acc = '0;
    endcase
    return acc;
  endfunction

  // Offer one request from the falling edge on, with random idle cycles in
  // front, and log its expected attack set once it is taken.
  task automatic push_request(input logic [OP_W-1:0] kind, input logic [SQ_W-1:0] sq,
                              input logic [BB_W-1:0] occ, input logic typed,
                              input logic [BB_W-1:0] want);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {{PAD_W{1'b0}}, occ, sq};
    do @(posedge clk); while (!in_tready);
    attacks_due.push_back(typed ? want : attack_set(kind, sq, occ));
  endtask

  // Random request. Sliders get extra weight since they carry the occupancy
  // logic; occupancy density varies so rays both run to the edge and stop early.
  task automatic push_random();
    logic [3:0]      pick;
    logic [OP_W-1:0] kind;
    logic [BB_W-1:0] occ;
    pick = 4'($urandom_range(0, 15));
    if (pick > 7) kind = pick[0] ? OP_ROOK : OP_BISHOP;
    else kind = pick[OP_W-1:0];
    case ($urandom_range(0, 4))
      0: occ = {$urandom, $urandom};
      1: occ = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      2: occ = {$urandom, $urandom} | {$urandom, $urandom};
      3: occ = 64'd1 << $urandom_range(0, 63);
      default: occ = $urandom_range(0, 1) ? ALL_OCC : '0;
    endcase
    push_request(kind, SQ_W'($urandom_range(0, 63)), occ, 1'b0, '0);
  endtask

  // Stop offering and wait for every outstanding result.
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (attacks_due.size() != 0) @(posedge clk);
  endtask

  // Receiver: random back-pressure, plus one long hold-off counted here.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left    = LONG_HOLD;
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_gap_pct);
      end
    end
  end

  // Result checker: every accepted result against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (attacks_due.size() == 0) begin
        fault_count++;
        if (fault_count <= REPORT_MAX)
          $display("unexpected result %h with nothing outstanding", out_tdata);
      end else begin
        if (out_tdata !== attacks_due[0]) begin
          fault_count++;
          if (fault_count <= REPORT_MAX)
            $display("attack set mismatch on result %0d: expected %h, got %h",
                     results_seen, attacks_due[0], out_tdata);
        end
        void'(attacks_due.pop_front());
      end
      results_seen++;
    end
  end

  // Watchdog: too long without a transfer on either side means a hang.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("chess_bitboard_attack_generator_core_tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int n;
    // reset held low from the start, released on a falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // phase 1: sender idles a little, receiver a lot
    send_gap_pct = 18;
    recv_gap_pct = 49;
    for (n = 0; n < NUM_PROBES; n++)
      push_request(PROBES[n].kind, PROBES[n].sq, PROBES[n].occ, PROBES[n].typed,
                   PROBES[n].want);
    for (n = 0; n < RANDOM_PER_PHASE; n++) push_random();

    // sender pauses until the pipeline is empty
    drain_results();

    // phase 2: the other way round
    send_gap_pct = 49;
    recv_gap_pct = 18;
    for (n = 0; n < RANDOM_PER_PHASE; n++) push_random();

    // phase 3: full rate; the receiver holds off once so the pipe backs up
    // and in_tready has to drop while requests keep coming
    send_gap_pct  = 0;
    recv_gap_pct  = 0;
    long_hold_req = 1'b1;
    for (n = 0; n < RANDOM_PER_PHASE; n++) push_random();

    drain_results();
    repeat (DRAIN_TAIL) @(posedge clk);

    if (fault_count == 0 && attacks_due.size() == 0) begin
      $display("chess_bitboard_attack_generator_core_tb passed");
    end else begin
      $display("chess_bitboard_attack_generator_core_tb failed");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/cbag_pkg.sv
hw/rtl/cbag_leaper.sv
hw/rtl/cbag_slider.sv
hw/rtl/chess_bitboard_attack_generator_core.sv
sim/chess_bitboard_attack_generator_core_tb.sv
